// ===== rtl/dct_pkg.sv =====
package dct_pkg;

	localparam int COL_W = 12;
	localparam int ROW_W = 16;
	localparam int CNT_W = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [2:0] CFG_FRAME_WIDTH   = 3'd0;
	localparam logic [2:0] CFG_FRAME_HEIGHT  = 3'd1;
	localparam logic [2:0] CFG_WINDOW_RADIUS = 3'd2;
	localparam logic [2:0] CFG_OMEGA_WEIGHT  = 3'd3;
	localparam logic [2:0] CFG_INV_AIR_BLUE  = 3'd4;
	localparam logic [2:0] CFG_INV_AIR_GREEN = 3'd5;
	localparam logic [2:0] CFG_INV_AIR_RED   = 3'd6;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam logic [23:0] NORM_CAP  = 24'hFF0000;
	localparam logic [7:0]  DARK_INIT = 8'hFF;
	localparam logic [33:0] ONE_Q14   = 34'd16384;
	localparam logic [33:0] HALF_LSB  = 34'd512;

	typedef struct packed {
		logic [COL_W-1:0] width;
		logic [ROW_W-1:0] height;
		logic [2:0]       radius;
	} geom_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PREP,
		BK_SCAN,
		BK_FLUSH,
		BK_MUL,
		BK_HOLD
	} back_state_t;

	function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [23:0] min24(input logic [23:0] a, input logic [23:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [23:0] scale_chan(input logic [7:0] v, input logic [19:0] inv);
		logic [27:0] p;
		p = {20'd0, v} * {8'd0, inv};
		return (p > {4'd0, NORM_CAP}) ? NORM_CAP : p[23:0];
	endfunction

endpackage

// ===== rtl/dct_line_store.sv =====
module dct_line_store #(
	parameter int DEPTH = 30720,
	parameter int AW = 15
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/dct_job_queue.sv =====
module dct_job_queue
	import dct_pkg::*;
#(
	parameter int W = 44
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         full,
	output logic         empty
);

	logic [W-1:0]      slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign dout  = slot_q[rp_q];
	assign full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);

endmodule

// ===== rtl/dct_front.sv =====
module dct_front
	import dct_pkg::*;
#(
	parameter int DEPTH = 30720,
	parameter int AW = 15,
	parameter int JW = 44
) (
	input  logic          clk,
	input  logic          arst_n,
	input  geom_t         geom,
	input  logic [19:0]   inv_blue,
	input  logic [19:0]   inv_green,
	input  logic [19:0]   inv_red,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          in_cmd,
	input  logic [7:0]    in_blue,
	input  logic [7:0]    in_green,
	input  logic [7:0]    in_red,
	output logic          st_we,
	output logic [AW-1:0] st_waddr,
	output logic [31:0]   st_wdata,
	output logic          q_push,
	output logic [JW-1:0] q_din,
	input  logic          q_full
);

	logic [AW-1:0]    wr_q, ib_q, ra_q;
	logic [COL_W-1:0] ic_q, oc_q;
	logic [ROW_W-1:0] ir_q, or_q;
	logic             fa_q;

	logic [AW-1:0]    wr_n, ib_n;
	logic [COL_W-1:0] ic_n, nc, w_m1;
	logic [ROW_W-1:0] ir_n, nr, h_m1;
	logic             fa_n, accept, pixel, due, last, oc_wrap, or_wrap;
	logic [ROW_W:0]   orow_r;
	logic [COL_W:0]   ocol_r;
	logic [AW:0]      ra_sum;
	logic [7:0]       dark;
	logic [23:0]      norm;

	assign pixel    = (in_cmd == CMD_PIXEL);
	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign h_m1     = geom.height - 16'd1;
	assign w_m1     = geom.width - 12'd1;

	assign dark = min8(in_blue, min8(in_green, in_red));
	assign norm = min24(scale_chan(in_blue, inv_blue),
		min24(scale_chan(in_green, inv_green), scale_chan(in_red, inv_red)));

	assign st_we    = accept && pixel;
	assign st_waddr = wr_q;
	assign st_wdata = {norm, dark};

	always_comb begin
		wr_n = wr_q;
		ic_n = ic_q;
		ir_n = ir_q;
		fa_n = fa_q;
		ib_n = ib_q;
		if (pixel) begin
			wr_n = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if ({1'b0, ic_q} + 13'd1 >= {1'b0, geom.width}) begin
				ic_n = '0;
				if ({1'b0, ir_q} + 17'd1 >= {1'b0, geom.height}) begin
					ir_n = '0;
					fa_n = 1'b1;
					ib_n = wr_n;
				end else begin
					ir_n = ir_q + 16'd1;
				end
			end else begin
				ic_n = ic_q + 12'd1;
			end
		end
	end

	assign orow_r  = {1'b0, or_q} + 17'(geom.radius);
	assign ocol_r  = {1'b0, oc_q} + 13'(geom.radius);
	assign nr      = (orow_r > {1'b0, h_m1}) ? h_m1 : orow_r[ROW_W-1:0];
	assign nc      = (ocol_r > {1'b0, w_m1}) ? w_m1 : ocol_r[COL_W-1:0];
	assign due     = fa_n || (ir_n > nr) || ((ir_n == nr) && (ic_n > nc));
	assign last    = (or_q == h_m1) && (oc_q == w_m1);
	assign oc_wrap = ({1'b0, oc_q} + 13'd1 >= {1'b0, geom.width});
	assign or_wrap = ({1'b0, or_q} + 17'd1 >= {1'b0, geom.height});

	assign q_push = accept && due;
	assign q_din  = {or_q, oc_q, ra_q, last};

	always_comb begin
		ra_sum = {1'b0, ra_q} + (AW+1)'(geom.width);
		if (ra_sum >= (AW+1)'(DEPTH)) begin
			ra_sum = ra_sum - (AW+1)'(DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			ib_q <= '0;
			ra_q <= '0;
			ic_q <= '0;
			ir_q <= '0;
			oc_q <= '0;
			or_q <= '0;
			fa_q <= 1'b0;
		end else if (accept) begin
			wr_q <= wr_n;
			ib_q <= ib_n;
			ic_q <= ic_n;
			ir_q <= ir_n;
			fa_q <= fa_n && !(due && oc_wrap && or_wrap);
			if (due) begin
				if (oc_wrap) begin
					oc_q <= '0;
					if (or_wrap) begin
						or_q <= '0;
						ra_q <= ib_n;
					end else begin
						or_q <= or_q + 16'd1;
						ra_q <= ra_sum[AW-1:0];
					end
				end else begin
					oc_q <= oc_q + 12'd1;
				end
			end
		end
	end

endmodule

// ===== rtl/dct_back.sv =====
module dct_back
	import dct_pkg::*;
#(
	parameter int DEPTH = 30720,
	parameter int AW = 15,
	parameter int JW = 44
) (
	input  logic             clk,
	input  logic             arst_n,
	input  geom_t            geom,
	input  logic [8:0]       omega,
	input  logic [JW-1:0]    q_dout,
	input  logic             q_empty,
	output logic             q_pop,
	output logic             rd_en,
	output logic [AW-1:0]    rd_addr,
	input  logic [31:0]      rd_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_dark,
	output logic [23:0]      out_trans,
	output logic [ROW_W-1:0] out_row,
	output logic [COL_W-1:0] out_col,
	output logic             out_last
);

	back_state_t st_q, st_n;

	logic [ROW_W-1:0] row_q, jrow, rmin;
	logic [COL_W-1:0] col_q, cmin_q, jcol, cmin, cmax, w_m1;
	logic             last_q, jlast, rdv_s1, scan_end;
	logic [AW-1:0]    addr_q, rowc_q, colad_q, jaddr;
	logic [2:0]       up_q, k;
	logic [CNT_W-1:0] nrows_q, ncols_q, xcnt_q, ycnt_q, nrows, ncols;
	logic [7:0]       dmin_q;
	logic [23:0]      nmin_q;
	logic [32:0]      prod_q;
	logic [ROW_W:0]   rmax_w, rmax;
	logic [COL_W:0]   cmax_w;
	logic [AW:0]      up_addr, start_addr, next_row, next_col;
	logic [33:0]      q_rnd;

	assign {jrow, jcol, jaddr, jlast} = q_dout;
	assign w_m1 = geom.width - 12'd1;

	assign k      = (jrow > 16'(geom.radius)) ? geom.radius : jrow[2:0];
	assign rmin   = jrow - 16'(k);
	assign rmax_w = {1'b0, jrow} + 17'(geom.radius);
	assign rmax   = (rmax_w > {1'b0, geom.height - 16'd1}) ? {1'b0, geom.height - 16'd1}
		: rmax_w;
	assign nrows  = CNT_W'(rmax - {1'b0, rmin});
	assign cmin   = (jcol > 12'(geom.radius)) ? jcol - 12'(geom.radius) : '0;
	assign cmax_w = {1'b0, jcol} + 13'(geom.radius);
	assign cmax   = (cmax_w > {1'b0, w_m1}) ? w_m1 : cmax_w[COL_W-1:0];
	assign ncols  = CNT_W'(cmax - cmin);

	always_comb begin
		up_addr = ({1'b0, addr_q} >= (AW+1)'(geom.width))
			? {1'b0, addr_q} - (AW+1)'(geom.width)
			: {1'b0, addr_q} + (AW+1)'(DEPTH) - (AW+1)'(geom.width);
		start_addr = {1'b0, addr_q} + (AW+1)'(cmin_q);
		if (start_addr >= (AW+1)'(DEPTH)) begin
			start_addr = start_addr - (AW+1)'(DEPTH);
		end
		next_row = {1'b0, rowc_q} + (AW+1)'(geom.width);
		if (next_row >= (AW+1)'(DEPTH)) begin
			next_row = next_row - (AW+1)'(DEPTH);
		end
		next_col = (colad_q == AW'(DEPTH - 1)) ? '0 : {1'b0, colad_q} + 1'b1;
	end

	assign scan_end = (ycnt_q == ncols_q) && (xcnt_q == nrows_q);

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			BK_IDLE:  if (!q_empty) st_n = BK_PREP;
			BK_PREP:  if (up_q == '0) st_n = BK_SCAN;
			BK_SCAN:  if (scan_end) st_n = BK_FLUSH;
			BK_FLUSH: st_n = BK_MUL;
			BK_MUL:   st_n = BK_HOLD;
			BK_HOLD:  if (out_ready) st_n = BK_IDLE;
			default:  st_n = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = 1'b0;
		rd_en     = 1'b0;
		out_valid = 1'b0;
		unique case (st_q)
			BK_IDLE: q_pop     = !q_empty;
			BK_SCAN: rd_en     = 1'b1;
			BK_HOLD: out_valid = 1'b1;
			default: ;
		endcase
	end

	assign rd_addr = colad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= BK_IDLE;
			rdv_s1 <= 1'b0;
		end else begin
			st_q   <= st_n;
			rdv_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rdv_s1) begin
			dmin_q <= min8(dmin_q, rd_data[7:0]);
			nmin_q <= min24(nmin_q, rd_data[31:8]);
		end
		unique case (st_q)
			BK_IDLE: begin
				row_q   <= jrow;
				col_q   <= jcol;
				last_q  <= jlast;
				addr_q  <= jaddr;
				up_q    <= k;
				cmin_q  <= cmin;
				nrows_q <= nrows;
				ncols_q <= ncols;
			end
			BK_PREP: begin
				if (up_q != '0) begin
					addr_q <= up_addr[AW-1:0];
					up_q   <= up_q - 3'd1;
				end else begin
					rowc_q  <= start_addr[AW-1:0];
					colad_q <= start_addr[AW-1:0];
					xcnt_q  <= '0;
					ycnt_q  <= '0;
					dmin_q  <= DARK_INIT;
					nmin_q  <= NORM_CAP;
				end
			end
			BK_SCAN: begin
				if (ycnt_q == ncols_q) begin
					ycnt_q  <= '0;
					xcnt_q  <= xcnt_q + 1'b1;
					rowc_q  <= next_row[AW-1:0];
					colad_q <= next_row[AW-1:0];
				end else begin
					ycnt_q  <= ycnt_q + 1'b1;
					colad_q <= next_col[AW-1:0];
				end
			end
			BK_MUL: prod_q <= {24'd0, omega} * {9'd0, nmin_q};
			default: ;
		endcase
	end

	assign q_rnd     = ({1'b0, prod_q} + HALF_LSB) >> 10;
	assign out_trans = 24'(ONE_Q14 - q_rnd);
	assign out_dark  = dmin_q;
	assign out_row   = row_q;
	assign out_col   = col_q;
	assign out_last  = last_q;

endmodule

// ===== rtl/dark_channel_transmission_core.sv =====
// Dark channel and transmission estimate over a raster BGR pixel stream. The input side takes
// one word per cycle while its four-entry job queue has room: it reduces each pixel to its
// channel minimum and its airlight-normalized minimum, writes both into the line store and
// queues every result whose (2r+1)x(2r+1) window is complete. The result side scans that
// window through the single read port of the line store, one entry per cycle, and finishes
// each result before it takes the next job from the queue. Results trail the input by r rows
// and r columns; at frame end drain words (tuser = 1) flush what is pending, and pixels of
// the next frame do the same. The line store needs no clearing pass after reset.
module dark_channel_transmission_core
	import dct_pkg::*;
#(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_RADIUS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // pixel_blue, pixel_green, pixel_red
	input  logic        s_axis_tuser,  // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // dark_value, transmission, out_row, out_col
	output logic        m_axis_tlast
);

	localparam int DEPTH = MAX_WIDTH * (2 * MAX_RADIUS + 1);
	localparam int AW = $clog2(DEPTH);
	localparam int JW = ROW_W + COL_W + AW + 1;

	logic [11:0] frame_width_q;
	logic [15:0] frame_height_q;
	logic [2:0]  window_radius_q;
	logic [8:0]  omega_weight_q;
	logic [19:0] inv_blue_q, inv_green_q, inv_red_q;
	geom_t       geom;

	logic          st_we, rd_en, q_push, q_pop, q_full, q_empty;
	logic [AW-1:0] st_waddr, rd_addr;
	logic [31:0]   st_wdata, rd_data;
	logic [JW-1:0] q_din, q_dout;

	logic [7:0]       out_dark;
	logic [23:0]      out_trans;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_col;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q   <= 12'd640;
			frame_height_q  <= 16'd480;
			window_radius_q <= 3'd7;
			omega_weight_q  <= 9'd243;
			inv_blue_q      <= 20'd257;
			inv_green_q     <= 20'd257;
			inv_red_q       <= 20'd257;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:   frame_width_q   <= cfg_data[11:0];
				CFG_FRAME_HEIGHT:  frame_height_q  <= cfg_data[15:0];
				CFG_WINDOW_RADIUS: window_radius_q <= cfg_data[2:0];
				CFG_OMEGA_WEIGHT:  omega_weight_q  <= cfg_data[8:0];
				CFG_INV_AIR_BLUE:  inv_blue_q      <= cfg_data;
				CFG_INV_AIR_GREEN: inv_green_q     <= cfg_data;
				CFG_INV_AIR_RED:   inv_red_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frame_width_q == '0) begin
			geom.width = 12'd1;
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			geom.width = 12'(MAX_WIDTH);
		end else begin
			geom.width = frame_width_q;
		end
		geom.height = (frame_height_q == '0) ? 16'd1 : frame_height_q;
		geom.radius = (32'(window_radius_q) > MAX_RADIUS) ? 3'(MAX_RADIUS) : window_radius_q;
	end

	dct_front #(.DEPTH(DEPTH), .AW(AW), .JW(JW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.inv_blue  (inv_blue_q),
		.inv_green (inv_green_q),
		.inv_red   (inv_red_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.in_blue   (s_axis_tdata[7:0]),
		.in_green  (s_axis_tdata[15:8]),
		.in_red    (s_axis_tdata[23:16]),
		.st_we     (st_we),
		.st_waddr  (st_waddr),
		.st_wdata  (st_wdata),
		.q_push    (q_push),
		.q_din     (q_din),
		.q_full    (q_full)
	);

	dct_line_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	dct_job_queue #(.W(JW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.full   (q_full),
		.empty  (q_empty)
	);

	dct_back #(.DEPTH(DEPTH), .AW(AW), .JW(JW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.omega     (omega_weight_q),
		.q_dout    (q_dout),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_dark  (out_dark),
		.out_trans (out_trans),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {5'd0, 11'(out_col), out_row, out_trans, out_dark};

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("job pushed into full queue");

	a_pop_not_while_scanning: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !q_pop && !m_axis_tvalid) else $error("window scan overlaps job handoff");

	a_last_at_corner: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
		out_row == geom.height - 16'd1 && out_col == geom.width - 12'd1)
		else $error("frame end flagged away from bottom right pixel");

endmodule
